// ----- sv/vrp_pkg.sv -----
// Package: codes, address constants and mirroring function for the video register port.
`default_nettype none
package vrp_pkg;

  localparam int unsigned VIDEO_DEPTH  = 16384;
  localparam int unsigned SPRITE_DEPTH = 256;
  localparam int unsigned VIDEO_AW     = $clog2(VIDEO_DEPTH);
  localparam int unsigned SPRITE_AW    = $clog2(SPRITE_DEPTH);

  localparam logic [1:0] OP_READ      = 2'd0;
  localparam logic [1:0] OP_WRITE     = 2'd1;
  localparam logic [1:0] OP_FRAME_END = 2'd2;

  localparam logic [2:0] REG_CTRL     = 3'd0;
  localparam logic [2:0] REG_MASK     = 3'd1;
  localparam logic [2:0] REG_STATUS   = 3'd2;
  localparam logic [2:0] REG_OAM_ADDR = 3'd3;
  localparam logic [2:0] REG_OAM_DATA = 3'd4;
  localparam logic [2:0] REG_SCROLL   = 3'd5;
  localparam logic [2:0] REG_ADDR     = 3'd6;
  localparam logic [2:0] REG_DATA     = 3'd7;

  localparam int unsigned CTRL_INC_BIT = 2;

  localparam logic [7:0]  STATUS_KEEP_MASK = 8'h60;
  localparam logic [7:0]  STATUS_VBLANK    = 8'h80;

  localparam logic [15:0] ADDR_SPACE_MASK  = 16'h3FFF;
  localparam logic [15:0] NAMETABLE_BASE   = 16'h2000;
  localparam logic [15:0] NAMETABLE_MASK   = 16'h2FFF;
  localparam logic [15:0] PALETTE_BASE     = 16'h3F00;
  localparam logic [15:0] PALETTE_END      = 16'h3F20;
  localparam logic [15:0] PALETTE_MASK     = 16'h3F1F;

  localparam logic [15:0] STRIDE_ROW       = 16'd32;
  localparam logic [15:0] STRIDE_ONE       = 16'd1;

  function automatic logic [15:0] mirror_addr(input logic [15:0] addr);
    logic [15:0] a;
    a = addr & ADDR_SPACE_MASK;
    if (a >= NAMETABLE_BASE && a < PALETTE_BASE) begin
      a = a & NAMETABLE_MASK;
    end else if (a >= PALETTE_END) begin
      a = a & PALETTE_MASK;
    end
    return a;
  endfunction

endpackage
`default_nettype wire

// ----- sv/vrp_ram.sv -----
// Generic single-clock RAM with one write port and one registered read port.
`default_nettype none
module vrp_ram #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned WIDTH = 8,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ----- sv/video_register_port_top.sv -----
// Top level: CPU-facing register port of a picture unit with sprite and video memories.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one bus event per transfer:
//   op_i selects register read, register write or frame end; reg_index_i picks
//   the register; write_data_i is the written byte.
//   Output channel (out_valid_o/out_ready_i) returns one read_data_o byte per
//   input transfer, zero for writes, frame ends and the unused op.
//   The input transfer moves the port into its EXEC state; out_valid_o rises
//   as the EXEC state ends and the result is registered.
//   The port takes no new item until the last one is done: the input transfer
//   issues the read of the sprite and video memories (synchronous), and the
//   EXEC state merges the read data, updates state and writes memory back.
//   One item is in flight at a time, so accesses never overlap in memory.
//   A new item is taken while the previous result is being transferred.
//   When the receiver stalls, the result holds in the output register and
//   in_ready_o stays low until it is taken.
//   Reset clears the register bytes, address latch, video and sprite
//   addresses and read buffer; memory contents are undefined until written.
`default_nettype none
module video_register_port_top
  import vrp_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [1:0] op_i,
  input  wire logic [2:0] reg_index_i,
  input  wire logic [7:0] write_data_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic      [7:0] read_data_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic        state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic [7:0]  out_data_q;
  logic [1:0]  op_q;
  logic [2:0]  idx_q;
  logic [7:0]  data_q;

  logic [7:0]  reg_file_q [8];
  logic [7:0]  reg_file_d [8];
  logic        latch_q, latch_d;
  logic [15:0] vaddr_q, vaddr_d;
  logic [7:0]  rbuf_q, rbuf_d;
  logic [7:0]  saddr_q, saddr_d;

  logic        in_xfer;
  logic        exec;
  logic [15:0] vaddr_mir;
  logic [15:0] vaddr_next;
  logic        is_palette;
  logic [7:0]  result;

  logic        vid_we, spr_we;
  logic [7:0]  vid_rdata, spr_rdata;

  assign in_ready_o = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign exec       = (state_q == ST_EXEC);

  assign vaddr_mir  = mirror_addr(vaddr_q);
  assign vaddr_next = vaddr_mir + (reg_file_q[REG_CTRL][CTRL_INC_BIT] ? STRIDE_ROW : STRIDE_ONE);
  assign is_palette = (vaddr_mir >= PALETTE_BASE) && (vaddr_mir < PALETTE_END);

  vrp_ram #(
    .DEPTH (VIDEO_DEPTH),
    .WIDTH (8)
  ) u_video_ram (
    .clk_i   (clk_i),
    .we_i    (vid_we),
    .waddr_i (vaddr_mir[VIDEO_AW-1:0]),
    .wdata_i (data_q),
    .re_i    (in_xfer),
    .raddr_i (vaddr_mir[VIDEO_AW-1:0]),
    .rdata_o (vid_rdata)
  );

  vrp_ram #(
    .DEPTH (SPRITE_DEPTH),
    .WIDTH (8)
  ) u_sprite_ram (
    .clk_i   (clk_i),
    .we_i    (spr_we),
    .waddr_i (saddr_q[SPRITE_AW-1:0]),
    .wdata_i (data_q),
    .re_i    (in_xfer),
    .raddr_i (saddr_q[SPRITE_AW-1:0]),
    .rdata_o (spr_rdata)
  );

  always_comb begin
    reg_file_d = reg_file_q;
    latch_d    = latch_q;
    vaddr_d    = vaddr_q;
    rbuf_d     = rbuf_q;
    saddr_d    = saddr_q;
    result     = 8'h00;
    vid_we     = 1'b0;
    spr_we     = 1'b0;
    if (exec) begin
      case (op_q)
        OP_READ: begin
          result = reg_file_q[idx_q];
          case (idx_q)
            REG_STATUS: begin
              reg_file_d[REG_STATUS] = reg_file_q[REG_STATUS] & STATUS_KEEP_MASK;
              latch_d = 1'b0;
            end
            REG_OAM_DATA: begin
              result = spr_rdata;
            end
            REG_DATA: begin
              if (is_palette) begin
                result = vid_rdata;
              end else begin
                result = rbuf_q;
                rbuf_d = vid_rdata;
              end
              vaddr_d = vaddr_next;
            end
            default: begin
            end
          endcase
        end
        OP_WRITE: begin
          reg_file_d[idx_q] = data_q;
          case (idx_q)
            REG_ADDR: begin
              if (!latch_q) begin
                vaddr_d = {data_q, 8'h00};
              end else begin
                vaddr_d = vaddr_q | {8'h00, data_q};
              end
              latch_d = ~latch_q;
            end
            REG_DATA: begin
              vid_we  = 1'b1;
              vaddr_d = vaddr_next;
            end
            REG_OAM_ADDR: begin
              saddr_d = data_q;
            end
            REG_OAM_DATA: begin
              spr_we  = 1'b1;
              saddr_d = saddr_q + 8'd1;
            end
            default: begin
            end
          endcase
        end
        OP_FRAME_END: begin
          reg_file_d[REG_STATUS] = reg_file_q[REG_STATUS] | STATUS_VBLANK;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_d     = ST_IDLE;
        out_valid_d = 1'b1;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      latch_q     <= 1'b0;
      vaddr_q     <= 16'h0000;
      rbuf_q      <= 8'h00;
      saddr_q     <= 8'h00;
      for (int i = 0; i < 8; i++) begin
        reg_file_q[i] <= 8'h00;
      end
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      latch_q     <= latch_d;
      vaddr_q     <= vaddr_d;
      rbuf_q      <= rbuf_d;
      saddr_q     <= saddr_d;
      reg_file_q  <= reg_file_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      op_q   <= op_i;
      idx_q  <= reg_index_i;
      data_q <= write_data_i;
    end
    if (exec) begin
      out_data_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign read_data_o = out_data_q;

endmodule
`default_nettype wire
